[rtl/tc3_pkg.sv]
// Shared types and constants for the 3-bit processor step block.
// Used by the channel interfaces, the data memory, the execute logic and the top level.
package tc3_pkg;

  localparam int WORD_W    = 3;
  localparam int PC_W      = 9;
  localparam int MEM_WORDS = 64;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PC_W-1:0]   pc_t;

  typedef enum logic [WORD_W-1:0] {
    OP_HALT   = 3'd0,
    OP_MOVL   = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_CMP    = 3'd4,
    OP_JEQ    = 3'd5,
    OP_JGT    = 3'd6,
    OP_MOVOUT = 3'd7
  } op_t;

  // Architectural state other than data memory
  typedef struct packed {
    pc_t  pc;
    logic eq;
    logic gt;
    logic halt;
  } cpu_state_t;

  // Data memory write request
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } mem_wr_t;

endpackage

[rtl/tc3_instr_if.sv]
// Instruction channel: valid/ready handshake with opcode and three operand fields.
// Depends on tc3_pkg for the field widths.
interface tc3_instr_if import tc3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t cmd;
  word_t field_a;
  word_t field_b;
  word_t field_c;

  modport source (output valid, output cmd, output field_a, output field_b,
                  output field_c, input ready);
  modport sink   (input valid, input cmd, input field_a, input field_b,
                  input field_c, output ready);
endinterface

[rtl/tc3_result_if.sv]
// Result channel: valid/ready handshake with pc, flags and memory write report.
// Depends on tc3_pkg for the field widths.
interface tc3_result_if import tc3_pkg::*; ();
  logic  valid;
  logic  ready;
  pc_t   next_pc;
  logic  halted;
  logic  mem_written;
  addr_t write_address;
  word_t write_value;
  logic  equal_mark;
  logic  greater_mark;

  modport source (output valid, output next_pc, output halted, output mem_written,
                  output write_address, output write_value, output equal_mark,
                  output greater_mark, input ready);
  modport sink   (input valid, input next_pc, input halted, input mem_written,
                  input write_address, input write_value, input equal_mark,
                  input greater_mark, output ready);
endinterface

[rtl/tc3_dmem.sv]
// Data memory: 64 words of 3 bits, one write port, two registered read ports.
// Per-word valid bits give zero reads after reset; depends on tc3_pkg.
module tc3_dmem import tc3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mem_wr_t wr,
  input  logic    rd_en,
  input  addr_t   raddr0,
  input  addr_t   raddr1,
  output word_t   rdata0,
  output word_t   rdata1
);

  word_t                mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // Pass a same-cycle write straight through to the reader
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == raddr0) begin
        rdata0 <= wr.data;
      end else begin
        rdata0 <= vld[raddr0] ? mem[raddr0] : '0;
      end
      if (wr.en && wr.addr == raddr1) begin
        rdata1 <= wr.data;
      end else begin
        rdata1 <= vld[raddr1] ? mem[raddr1] : '0;
      end
    end
  end

endmodule

[rtl/tc3_exec.sv]
// Execute logic: decodes one instruction and forms the next state and memory write.
// Purely combinational; depends on tc3_pkg.
module tc3_exec import tc3_pkg::*; (
  input  word_t      cmd,
  input  word_t      field_a,
  input  word_t      field_b,
  input  word_t      field_c,
  input  word_t      opnd0,
  input  word_t      opnd1,
  input  cpu_state_t cur,
  output cpu_state_t nxt,
  output mem_wr_t    wr
);

  op_t op;
  pc_t target;

  assign op     = op_t'(cmd);
  assign target = {field_a, field_b, field_c};

  always_comb begin
    nxt    = cur;
    nxt.pc = cur.pc + pc_t'(1);
    wr     = '0;
    unique case (op)
      OP_HALT: begin
        nxt.halt = 1'b1;
        nxt.pc   = '0;
      end
      OP_MOVL: begin
        wr.en   = 1'b1;
        wr.addr = {field_b, field_c};
        wr.data = field_a;
      end
      OP_ADD: begin
        wr.en   = 1'b1;
        wr.addr = {{WORD_W{1'b0}}, field_c};
        wr.data = opnd0 + opnd1;
      end
      OP_SUB: begin
        wr.en   = 1'b1;
        wr.addr = {{WORD_W{1'b0}}, field_c};
        wr.data = opnd0 - opnd1;
      end
      OP_CMP: begin
        nxt.eq = (opnd0 == opnd1);
        nxt.gt = (opnd0 > opnd1);
      end
      OP_JEQ: begin
        if (cur.eq) nxt.pc = target;
      end
      OP_JGT: begin
        if (cur.gt) nxt.pc = target;
      end
      OP_MOVOUT: begin
        wr.en   = 1'b1;
        wr.addr = {field_b, field_c};
        wr.data = opnd0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[rtl/tiny_3bit_cpu_step.sv]
// Throughput: one instruction per cycle unless the result sink stalls; set by the
//   memory read, execute and write-back loop, with same-cycle writes passed through
//   to the read registers.
// Reset (rst, synchronous): pc, flags, halted mark and source page go to zero; data
//   memory reads as zero through per-word valid bits, so no clearing pass is needed.
module tiny_3bit_cpu_step import tc3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_wr_en,
  input  word_t cfg_wr_data,
  tc3_instr_if.sink    instr,
  tc3_result_if.source result
);

  word_t      source_page;
  cpu_state_t state;
  cpu_state_t state_next;
  mem_wr_t    wr;

  logic  s1_valid;
  word_t s1_cmd;
  word_t s1_a;
  word_t s1_b;
  word_t s1_c;
  word_t opnd0;
  word_t opnd1;
  addr_t raddr0;
  addr_t raddr1;
  logic  s1_fire;
  logic  accept;
  mem_wr_t mem_wr;

  assign s1_fire     = s1_valid && (!result.valid || result.ready);
  assign instr.ready = !s1_valid || s1_fire;
  assign accept      = instr.valid && instr.ready;

  always_comb begin
    raddr0 = {{WORD_W{1'b0}}, instr.field_a};
    raddr1 = {{WORD_W{1'b0}}, instr.field_b};
    if (instr.cmd == OP_MOVOUT) raddr0 = {source_page, instr.field_a};
    if (instr.cmd == OP_CMP)    raddr1 = {instr.field_b, instr.field_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_page <= '0;
    end else if (cfg_wr_en) begin
      source_page <= cfg_wr_data;
    end
  end

  // Instruction register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= instr.cmd;
      s1_a   <= instr.field_a;
      s1_b   <= instr.field_b;
      s1_c   <= instr.field_c;
    end
  end

  assign mem_wr = '{en: wr.en && s1_fire, addr: wr.addr, data: wr.data};

  tc3_dmem u_dmem (
    .clk    (clk),
    .rst    (rst),
    .wr     (mem_wr),
    .rd_en  (accept),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (opnd0),
    .rdata1 (opnd1)
  );

  tc3_exec u_exec (
    .cmd     (s1_cmd),
    .field_a (s1_a),
    .field_b (s1_b),
    .field_c (s1_c),
    .opnd0   (opnd0),
    .opnd1   (opnd1),
    .cur     (state),
    .nxt     (state_next),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.next_pc       <= state_next.pc;
      result.halted        <= state_next.halt;
      result.mem_written   <= wr.en;
      result.write_address <= wr.addr;
      result.write_value   <= wr.data;
      result.equal_mark    <= state_next.eq;
      result.greater_mark  <= state_next.gt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(state.halt) |-> state.halt)
    else $error("halted mark cleared without reset");

  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_cmd == OP_HALT |=> state.pc == '0 && state.halt)
    else $error("halt did not send pc to zero");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.mem_written |->
      result.write_address == '0 && result.write_value == '0)
    else $error("write report not zero without a memory write");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> result.valid)
    else $error("executed instruction produced no result");

endmodule
